>>> rtl/core/paed_pkg.sv
// Shared types and constants for the PWM angle decoder core.
// Used by the controller, the datapath, the top level and the checker.
package paed_pkg;

    localparam int CAPTURE_BITS_DEFAULT = 16;

    // field widths
    localparam int TICKS_W   = 13;  // ticks per frame, scaled ticks, position code
    localparam int THR_W     = 16;
    localparam int SCALE_W   = 15;
    localparam int FULL_W    = 27;
    localparam int ANGLE_W   = 28;
    localparam int TURNS_W   = 16;
    localparam int MULTI_W   = 44;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 27;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TICKS_PER_FRAME = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP_HIGH       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WRAP_LOW        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_SCALE     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_TURN       = 3'd4;

    // register reset values
    localparam logic [TICKS_W-1:0] TICKS_RESET     = 13'd4119;
    localparam logic [THR_W-1:0]   WRAP_HIGH_RESET = 16'd50000;
    localparam logic [THR_W-1:0]   WRAP_LOW_RESET  = 16'd10000;
    localparam logic [SCALE_W-1:0] SCALE_RESET     = 15'd25736;
    localparam logic [FULL_W-1:0]  FULL_TURN_RESET = 27'd105414357;

    localparam logic [TICKS_W-1:0] VALID_LIMIT = 13'd12;
    localparam logic [TICKS_W-1:0] CODE_OFFSET = 13'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_CODE,
        ST_TURN,
        ST_LOAD
    } paed_state_t;

    typedef struct packed {
        logic capture;   // latch rise and fall capture times
        logic check;     // update width/turns, form product, set up divide
        logic div_step;  // one quotient bit
        logic code;      // position code and angle
        logic turn;      // turns times full turn
        logic load_out;  // load result register
    } paed_cmd_t;

    typedef struct packed {
        logic drop;      // fall earlier than rise
    } paed_status_t;

endpackage

>>> rtl/core/paed_ctrl.sv
// Sequencer for the PWM angle decoder: state machine, divide step counter
// and result-valid flag. Depends on paed_pkg.
module paed_ctrl
    import paed_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    input  paed_status_t status,
    output paed_cmd_t    cmd
);

    localparam int CntW = $clog2(TICKS_W);

    paed_state_t         state_reg, state_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.drop) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.check  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(TICKS_W - 1))
                    state_next = ST_CODE;
            end
            ST_CODE: begin
                cmd.code   = 1'b1;
                state_next = ST_TURN;
            end
            ST_TURN: begin
                cmd.turn   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/core/paed_datapath.sv
// Datapath of the PWM angle decoder: config registers, width and turn
// state, restoring divider, angle multipliers and result register. Uses paed_pkg.
module paed_datapath
    import paed_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  paed_cmd_t                     cmd,
    output paed_status_t                  status,
    input  logic                          cfg_we,
    input  logic [CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [CFG_DATA_W-1:0]         cfg_wdata,
    input  logic [CAPTURE_BITS-1:0]       s_rise_time,
    input  logic [CAPTURE_BITS-1:0]       s_fall_time,
    output logic                          m_valid_res,
    output logic [TICKS_W-1:0]            m_position_code,
    output logic signed [TURNS_W-1:0]     m_turn_count,
    output logic [ANGLE_W-1:0]            m_angle,
    output logic signed [MULTI_W-1:0]     m_multiturn_angle
);

    localparam int CmpW  = (CAPTURE_BITS > THR_W) ? CAPTURE_BITS : THR_W;
    localparam int ProdW = TICKS_W + CAPTURE_BITS;

    // config
    logic [TICKS_W-1:0] ticks_reg;
    logic [THR_W-1:0]   wrap_high_reg, wrap_low_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [FULL_W-1:0]  full_turn_reg;

    // state
    logic [CAPTURE_BITS-1:0] last_width_reg;
    logic [TURNS_W-1:0]      turns_reg;

    // working
    logic [CAPTURE_BITS-1:0] rise_reg, fall_reg;
    logic                    fall_zero_reg;
    logic [CAPTURE_BITS-1:0] rem_reg;
    logic [TICKS_W-1:0]      lo_reg, quot_reg;
    logic                    res_valid_reg;
    logic [TICKS_W-1:0]      code_reg;
    logic [ANGLE_W-1:0]      angle_reg;
    logic signed [MULTI_W-1:0] mt_prod_reg;

    // result register
    logic                      out_valid_res_reg;
    logic [TICKS_W-1:0]        out_code_reg;
    logic [TURNS_W-1:0]        out_turns_reg;
    logic [ANGLE_W-1:0]        out_angle_reg;
    logic signed [MULTI_W-1:0] out_multi_reg;

    logic [CAPTURE_BITS-1:0] width;
    logic [CmpW-1:0]         prev_c, width_c, high_c, low_c;
    logic                    wrap_up, wrap_down;
    logic [ProdW-1:0]        prod;
    logic [CAPTURE_BITS:0]   trial;
    logic                    ge;
    logic [CAPTURE_BITS:0]   trial_sub;
    logic [TICKS_W-1:0]      scaled;
    logic                    valid_now;
    logic [TICKS_W-1:0]      code_now;
    logic signed [MULTI_W-1:0] multi_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg     <= TICKS_RESET;
            wrap_high_reg <= WRAP_HIGH_RESET;
            wrap_low_reg  <= WRAP_LOW_RESET;
            scale_reg     <= SCALE_RESET;
            full_turn_reg <= FULL_TURN_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_TICKS_PER_FRAME: ticks_reg     <= cfg_wdata[TICKS_W-1:0];
                REG_WRAP_HIGH:       wrap_high_reg <= cfg_wdata[THR_W-1:0];
                REG_WRAP_LOW:        wrap_low_reg  <= cfg_wdata[THR_W-1:0];
                REG_ANGLE_SCALE:     scale_reg     <= cfg_wdata[SCALE_W-1:0];
                REG_FULL_TURN:       full_turn_reg <= cfg_wdata[FULL_W-1:0];
                default: ;
            endcase
        end
    end

    assign width       = fall_reg - rise_reg;
    assign status.drop = fall_reg < rise_reg;

    assign prev_c  = CmpW'(last_width_reg);
    assign width_c = CmpW'(width);
    assign high_c  = CmpW'(wrap_high_reg);
    assign low_c   = CmpW'(wrap_low_reg);
    assign wrap_up   = (prev_c > high_c) && (width_c < low_c);
    assign wrap_down = (prev_c < low_c) && (width_c > high_c);

    assign prod = ProdW'(ticks_reg) * ProdW'(width);

    // restoring divide; quotient never exceeds ticks_per_frame as width <= fall
    assign trial     = {rem_reg, lo_reg[TICKS_W-1]};
    assign ge        = trial >= {1'b0, fall_reg};
    assign trial_sub = trial - {1'b0, fall_reg};

    assign scaled    = fall_zero_reg ? '0 : quot_reg;
    assign valid_now = scaled > VALID_LIMIT;
    assign code_now  = (scaled > CODE_OFFSET) ? (scaled - CODE_OFFSET) : '0;

    assign multi_sum = mt_prod_reg + $signed({{(MULTI_W-ANGLE_W){1'b0}}, angle_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_width_reg <= '0;
            turns_reg      <= '0;
        end else if (cmd.check) begin
            last_width_reg <= width;
            if (wrap_up)
                turns_reg <= turns_reg + 1'b1;
            else if (wrap_down)
                turns_reg <= turns_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rise_reg <= s_rise_time;
            fall_reg <= s_fall_time;
        end
        if (cmd.check) begin
            fall_zero_reg <= (fall_reg == '0);
            rem_reg       <= prod[ProdW-1:TICKS_W];
            lo_reg        <= prod[TICKS_W-1:0];
        end
        if (cmd.div_step) begin
            rem_reg  <= ge ? trial_sub[CAPTURE_BITS-1:0] : trial[CAPTURE_BITS-1:0];
            lo_reg   <= {lo_reg[TICKS_W-2:0], 1'b0};
            quot_reg <= {quot_reg[TICKS_W-2:0], ge};
        end
        if (cmd.code) begin
            res_valid_reg <= valid_now;
            code_reg      <= valid_now ? code_now : '0;
            angle_reg     <= valid_now ? ANGLE_W'(code_now) * ANGLE_W'(scale_reg) : '0;
        end
        if (cmd.turn)
            mt_prod_reg <= $signed(turns_reg) * $signed({1'b0, full_turn_reg});
        if (cmd.load_out) begin
            out_valid_res_reg <= res_valid_reg;
            out_code_reg      <= code_reg;
            out_turns_reg     <= turns_reg;
            out_angle_reg     <= angle_reg;
            out_multi_reg     <= res_valid_reg ? multi_sum : '0;
        end
    end

    assign m_valid_res       = out_valid_res_reg;
    assign m_position_code   = out_code_reg;
    assign m_turn_count      = $signed(out_turns_reg);
    assign m_angle           = out_angle_reg;
    assign m_multiturn_angle = out_multi_reg;

endmodule

>>> rtl/core/pwm_angle_encoder_decoder_core.sv
// PWM angle decoder core: one beat in carries the rising and falling capture
// times of a sensor PWM frame; one beat out carries validity, position code,
// turn count, Q.24 angle and Q.24 multiturn angle. A frame whose fall time is
// earlier than its rise time is dropped with no output beat and no state
// change. A frame passes through accept, width check, 13 restoring-divide
// steps of the ticks scaling, angle multiply, turn multiply and load, which
// waits until the output is free; a dropped frame returns to idle after the
// width check. One frame is processed at a time; the result register lets
// the next input beat be taken while a result waits on m_ready.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) land at once and must
// only be issued while the core is idle. Depends on paed_pkg.
module pwm_angle_encoder_decoder_core
    import paed_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    // input beats
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CAPTURE_BITS-1:0]   s_rise_time,
    input  logic [CAPTURE_BITS-1:0]   s_fall_time,
    // result beats
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_valid_res,
    output logic [TICKS_W-1:0]        m_position_code,
    output logic signed [TURNS_W-1:0] m_turn_count,
    output logic [ANGLE_W-1:0]        m_angle,
    output logic signed [MULTI_W-1:0] m_multiturn_angle
);

    paed_cmd_t    cmd;
    paed_status_t status;

    // sequencer: states, divide count, output valid
    paed_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, config and turn state
    paed_datapath #(
        .CAPTURE_BITS (CAPTURE_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_rise_time       (s_rise_time),
        .s_fall_time       (s_fall_time),
        .m_valid_res       (m_valid_res),
        .m_position_code   (m_position_code),
        .m_turn_count      (m_turn_count),
        .m_angle           (m_angle),
        .m_multiturn_angle (m_multiturn_angle)
    );

endmodule

>>> rtl/core/paed_checker.sv
// Port-level checks for the PWM angle decoder core, bound to the top level.
// Depends on paed_pkg.
module paed_checker
    import paed_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_valid_res,
    input logic [TICKS_W-1:0]        m_position_code,
    input logic signed [TURNS_W-1:0] m_turn_count,
    input logic [ANGLE_W-1:0]        m_angle,
    input logic signed [MULTI_W-1:0] m_multiturn_angle
);

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position_code) &&
            $stable(m_angle) && $stable(m_multiturn_angle) && $stable(m_turn_count))
        else $error("result beat changed while stalled");

    // an invalid result carries zero code and angles
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_position_code == '0 && m_angle == '0 &&
            m_multiturn_angle == '0)
        else $error("invalid result with non-zero fields");

    // one frame at a time: busy straight after an input beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a frame is in work");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pwm_angle_encoder_decoder_core paed_checker #(
    .CAPTURE_BITS (CAPTURE_BITS)
) u_paed_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_valid_res       (m_valid_res),
    .m_position_code   (m_position_code),
    .m_turn_count      (m_turn_count),
    .m_angle           (m_angle),
    .m_multiturn_angle (m_multiturn_angle)
);
